### rtl/core/sha1_pkg.sv
package sha1_pkg;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hefcdab89;
    localparam logic [31:0] H2_INIT = 32'h98badcfe;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // one word for the back end, with its place in the message
    typedef struct packed {
        logic [31:0] word;
        logic        block_end;
        logic        msg_end;
    } blk_word_t;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        rotl1 = {x[30:0], x[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] x);
        rotl5 = {x[26:0], x[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] x);
        rotl30 = {x[1:0], x[31:2]};
    endfunction

endpackage

### rtl/core/sha1_if.sv
interface sha1_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
    modport source (output valid, data_word, valid_bytes, last_word, input ready);
    modport sink (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_of_digest;
    modport source (output valid, digest_word, word_index, last_of_digest, input ready);
    modport sink (input valid, digest_word, word_index, last_of_digest, output ready);
endinterface

### rtl/core/sha1_front.sv
module sha1_front (
    input  logic                     clk,
    input  logic                     rst_n,
    sha1_in_if.sink                  in_ch,
    output sha1_pkg::blk_word_t      wr_data,
    output logic                     wr_valid,
    input  logic                     wr_ready
);
    localparam logic [1:0] ST_TAKE = 2'd0;
    localparam logic [1:0] ST_PAD  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_LEN  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [60:0] bytes_reg, bytes_next;
    logic [3:0]  wib_reg, wib_next;
    logic        len_lo_reg, len_lo_next;
    logic [2:0]  vb;
    logic [31:0] mask, pad_word;
    logic [63:0] bits;

    always_comb
    begin
        vb = (in_ch.valid_bytes > 3'd4) ? 3'd4 : in_ch.valid_bytes;
        unique case (vb)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'hff00_0000;
            3'd2:    mask = 32'hffff_0000;
            3'd3:    mask = 32'hffff_ff00;
            default: mask = 32'hffff_ffff;
        endcase
        unique case (vb)
            3'd0:    pad_word = {sha1_pkg::PAD_BYTE, 24'd0};
            3'd1:    pad_word = {8'd0, sha1_pkg::PAD_BYTE, 16'd0};
            3'd2:    pad_word = {16'd0, sha1_pkg::PAD_BYTE, 8'd0};
            default: pad_word = {24'd0, sha1_pkg::PAD_BYTE};
        endcase
        bits = {bytes_reg, 3'd0};
    end

    always_comb
    begin
        state_next   = state_reg;
        bytes_next   = bytes_reg;
        wib_next     = wib_reg;
        len_lo_next  = len_lo_reg;
        in_ch.ready  = 1'b0;
        wr_valid     = 1'b0;
        wr_data.word = 32'd0;
        wr_data.msg_end = 1'b0;
        unique case (state_reg)
            ST_TAKE:
            begin
                in_ch.ready = wr_ready;
                wr_valid    = in_ch.valid;
                if (!in_ch.last_word)
                begin
                    wr_data.word = in_ch.data_word;
                end
                else if (vb == 3'd4)
                begin
                    wr_data.word = in_ch.data_word;
                end
                else
                begin
                    wr_data.word = (in_ch.data_word & mask) | pad_word;
                end
                if (in_ch.valid && wr_ready)
                begin
                    wib_next = wib_reg + 4'd1;
                    if (!in_ch.last_word)
                    begin
                        bytes_next = bytes_reg + 61'd4;
                    end
                    else
                    begin
                        bytes_next = bytes_reg + {58'd0, vb};
                        if (vb == 3'd4)
                            state_next = ST_PAD;
                        else if (wib_reg + 4'd1 == 4'd14)
                            state_next = ST_LEN;
                        else
                            state_next = ST_ZERO;
                    end
                end
            end
            ST_PAD:
            begin
                wr_valid     = 1'b1;
                wr_data.word = {sha1_pkg::PAD_BYTE, 24'd0};
                if (wr_ready)
                begin
                    wib_next   = wib_reg + 4'd1;
                    state_next = (wib_reg + 4'd1 == 4'd14) ? ST_LEN : ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                wr_valid     = 1'b1;
                wr_data.word = 32'd0;
                if (wr_ready)
                begin
                    wib_next = wib_reg + 4'd1;
                    if (wib_reg + 4'd1 == 4'd14)
                        state_next = ST_LEN;
                end
            end
            default:
            begin
                wr_valid        = 1'b1;
                wr_data.word    = len_lo_reg ? bits[31:0] : bits[63:32];
                wr_data.msg_end = len_lo_reg;
                if (wr_ready)
                begin
                    wib_next    = wib_reg + 4'd1;
                    len_lo_next = !len_lo_reg;
                    if (len_lo_reg)
                    begin
                        state_next = ST_TAKE;
                        bytes_next = 61'd0;
                        wib_next   = 4'd0;
                    end
                end
            end
        endcase
        wr_data.block_end = (wib_reg == 4'd15);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_TAKE;
            bytes_reg  <= 61'd0;
            wib_reg    <= 4'd0;
            len_lo_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bytes_reg  <= bytes_next;
            wib_reg    <= wib_next;
            len_lo_reg <= len_lo_next;
        end
    end

`ifndef SYNTHESIS
    a_len_at_14: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEN && !len_lo_reg) |-> wib_reg == 4'd14)
        else $error("length high word not at word 14");
    a_end_at_15: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_valid && wr_data.msg_end) |-> wib_reg == 4'd15)
        else $error("message end not at block end");
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_TAKE) |-> !in_ch.ready)
        else $error("input taken while padding");
`endif
endmodule

### rtl/core/sha1_fifo.sv
module sha1_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1_pkg::blk_word_t wr_data,
    input  logic                wr_valid,
    output logic                wr_ready,
    output sha1_pkg::blk_word_t rd_data,
    output logic                rd_valid,
    input  logic                rd_ready
);
    sha1_pkg::blk_word_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 3'd4);
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= wp_reg + 2'd1;
            if (do_rd)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, do_wr} - {2'd0, do_rd};
        end
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4) else $error("queue count out of range");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[1:0] == wp_reg - rp_reg)) else $error("queue pointers disagree");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> cnt_reg == $past(cnt_reg) + 3'd1)
        else $error("queue count did not grow");
`endif
endmodule

### rtl/core/sha1_back.sv
module sha1_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1_pkg::blk_word_t rd_data,
    input  logic                rd_valid,
    output logic                rd_ready,
    sha1_out_if.source          out_ch
);
    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_RND  = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]  state_reg;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]  rnd_reg;
    logic [3:0]  wi_reg;
    logic        fin_reg;
    logic [2:0]  oi_reg;
    logic        ovalid_reg;
    logic [31:0] wnew, wuse, fn, kk, t;
    logic [3:0]  r4;

    assign r4       = rnd_reg[3:0];
    assign rd_ready = (state_reg == ST_LOAD);

    always_comb
    begin
        wnew = sha1_pkg::rotl1(w_reg[r4 + 4'd13] ^ w_reg[r4 + 4'd8]
                               ^ w_reg[r4 + 4'd2] ^ w_reg[r4]);
        wuse = (rnd_reg < 7'd16) ? w_reg[r4] : wnew;
        if (rnd_reg < 7'd20)
        begin
            fn = (b_reg & c_reg) | (~b_reg & d_reg);
            kk = sha1_pkg::K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            fn = b_reg ^ c_reg ^ d_reg;
            kk = sha1_pkg::K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            fn = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            kk = sha1_pkg::K2;
        end
        else
        begin
            fn = b_reg ^ c_reg ^ d_reg;
            kk = sha1_pkg::K3;
        end
        t = sha1_pkg::rotl5(a_reg) + fn + e_reg + wuse + kk;
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid && state_reg == ST_LOAD)
            w_reg[wi_reg] <= rd_data.word;
        else if (state_reg == ST_RND && rnd_reg >= 7'd16)
            w_reg[r4] <= wnew;
        if (state_reg == ST_RND)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= sha1_pkg::rotl30(b_reg);
            b_reg <= a_reg;
            a_reg <= t;
        end
        else
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            h_reg[0]   <= sha1_pkg::H0_INIT;
            h_reg[1]   <= sha1_pkg::H1_INIT;
            h_reg[2]   <= sha1_pkg::H2_INIT;
            h_reg[3]   <= sha1_pkg::H3_INIT;
            h_reg[4]   <= sha1_pkg::H4_INIT;
            rnd_reg    <= 7'd0;
            wi_reg     <= 4'd0;
            fin_reg    <= 1'b0;
            oi_reg     <= 3'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (rd_valid)
                    begin
                        wi_reg <= wi_reg + 4'd1;
                        if (rd_data.block_end)
                        begin
                            fin_reg   <= rd_data.msg_end;
                            rnd_reg   <= 7'd0;
                            state_reg <= ST_RND;
                        end
                    end
                end
                ST_RND:
                begin
                    if (rnd_reg == 7'd79)
                    begin
                        rnd_reg   <= 7'd0;
                        state_reg <= ST_ADD;
                    end
                    else
                        rnd_reg <= rnd_reg + 7'd1;
                end
                ST_ADD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    rnd_reg  <= 7'd0;
                    if (fin_reg)
                    begin
                        oi_reg     <= 3'd0;
                        ovalid_reg <= 1'b1;
                        state_reg  <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                default:
                begin
                    if (out_ch.ready)
                    begin
                        if (oi_reg == 3'd4)
                        begin
                            ovalid_reg <= 1'b0;
                            h_reg[0]   <= sha1_pkg::H0_INIT;
                            h_reg[1]   <= sha1_pkg::H1_INIT;
                            h_reg[2]   <= sha1_pkg::H2_INIT;
                            h_reg[3]   <= sha1_pkg::H3_INIT;
                            h_reg[4]   <= sha1_pkg::H4_INIT;
                            state_reg  <= ST_LOAD;
                        end
                        oi_reg <= oi_reg + 3'd1;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (oi_reg)
            3'd0:    out_ch.digest_word = h_reg[0];
            3'd1:    out_ch.digest_word = h_reg[1];
            3'd2:    out_ch.digest_word = h_reg[2];
            3'd3:    out_ch.digest_word = h_reg[3];
            default: out_ch.digest_word = h_reg[4];
        endcase
    end

    assign out_ch.valid          = ovalid_reg;
    assign out_ch.word_index     = oi_reg;
    assign out_ch.last_of_digest = (oi_reg == 3'd4);

`ifndef SYNTHESIS
    a_valid_out: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> state_reg == ST_OUT) else $error("digest shown outside output");
    a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_reg <= 7'd79) else $error("round count out of range");
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> oi_reg <= 3'd4) else $error("digest index out of range");
`endif
endmodule

### rtl/core/sha1_message_digest.sv
// channel | dir | payload                                    | handshake
// in_ch   | in  | data_word[31:0] valid_bytes[2:0] last_word | valid/ready
// out_ch  | out | digest_word[31:0] word_index[2:0] last_of_digest | valid/ready
//
// a block of 16 words is loaded, then runs 80 rounds (one round
// per cycle in the single compression unit), then an add step
// the final word adds padding words at one a cycle while the queue has room, and one or two blocks
// rst_n is asynchronous, active low, and restores the initial chaining values
// the word queue lets input loading continue while the back end compresses
module sha1_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    sha1_in_if.sink     in_ch,
    sha1_out_if.source  out_ch
);
    sha1_pkg::blk_word_t wr_data, rd_data;
    logic wr_valid, wr_ready, rd_valid, rd_ready;

    // front end: counts bytes and builds padding and length words
    sha1_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .wr_data  (wr_data),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready)
    );

    // short word queue between front and back ends
    sha1_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (wr_data),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .rd_data  (rd_data),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready)
    );

    // back end: block buffer, 80-round compression, digest output
    sha1_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_data  (rd_data),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .out_ch   (out_ch)
    );
endmodule
